// ----- hw/rtl/msstk_pkg.sv -----
`default_nettype none
package msstk_pkg;

    localparam int STACKS     = 16;
    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 16;

    // Fixed field widths of the ports.
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 4;
    localparam int WORD_W  = 16;
    localparam int DEPTH_W = 7;

    // Slot numbers run 1..CAPACITY and marks run 0..CAPACITY.
    localparam int PTR_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int SIDX_W = $clog2(STACKS);
    localparam int BIDX_W = $clog2(STACKS + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH = 2'd0,
        KIND_POP  = 2'd1,
        KIND_PEEK = 2'd2,
        KIND_NOP  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PTR_NONE,
        PTR_PUSH,
        PTR_POP,
        PTR_SHIFT_UP,
        PTR_SHIFT_DOWN
    } ptr_op_t;

    // Pointer update: push and pop act on stack lo, shifts on stacks lo..hi.
    typedef struct packed {
        ptr_op_t           op;
        logic [BIDX_W-1:0] lo;
        logic [BIDX_W-1:0] hi;
    } ptr_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_UP_SCAN,
        ST_UP_PREP,
        ST_DN_SCAN,
        ST_DN_PREP,
        ST_MV_RD,
        ST_MV_WR,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/msstk_ptrs.sv -----
`default_nettype none
module msstk_ptrs
    import msstk_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ptr_cmd_t          cmd,
    input  wire logic [SIDX_W-1:0] top_idx,
    input  wire logic [BIDX_W-1:0] base_idx,
    output logic      [PTR_W-1:0]  top_rd,
    output logic      [PTR_W-1:0]  base_rd,
    output logic      [STACKS-1:0] free_vec,
    output logic      [STACKS-1:0] empty_vec
);

    logic [PTR_W-1:0] base_reg [STACKS+1];
    logic [PTR_W-1:0] top_reg  [STACKS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STACKS; i++)
            begin
                base_reg[i] <= PTR_W'((i * CAPACITY) / STACKS);
                top_reg[i]  <= PTR_W'((i * CAPACITY) / STACKS);
            end
            base_reg[STACKS] <= PTR_W'(CAPACITY);
        end
        else
        begin
            for (int i = 0; i < STACKS; i++)
            begin
                case (cmd.op)
                    PTR_PUSH:
                    begin
                        if (BIDX_W'(i) == cmd.lo)
                            top_reg[i] <= top_reg[i] + PTR_W'(1);
                    end
                    PTR_POP:
                    begin
                        if (BIDX_W'(i) == cmd.lo)
                            top_reg[i] <= top_reg[i] - PTR_W'(1);
                    end
                    PTR_SHIFT_UP:
                    begin
                        if (BIDX_W'(i) >= cmd.lo && BIDX_W'(i) <= cmd.hi)
                        begin
                            base_reg[i] <= base_reg[i] + PTR_W'(1);
                            top_reg[i]  <= top_reg[i] + PTR_W'(1);
                        end
                    end
                    PTR_SHIFT_DOWN:
                    begin
                        if (BIDX_W'(i) >= cmd.lo && BIDX_W'(i) <= cmd.hi)
                        begin
                            base_reg[i] <= base_reg[i] - PTR_W'(1);
                            top_reg[i]  <= top_reg[i] - PTR_W'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < STACKS; i++)
        begin
            free_vec[i]  = top_reg[i] < base_reg[i+1];
            empty_vec[i] = top_reg[i] == base_reg[i];
        end
    end

    assign top_rd  = top_reg[top_idx];
    assign base_rd = base_reg[base_idx];

endmodule
`default_nettype wire

// ----- hw/rtl/shared_array_multi_stack.sv -----
`default_nettype none
// A plain push, pop or peek passes through EXEC and then FINISH, which registers its result at
// the output once the output is free. A push into a stack that has met its neighbor first scans
// for room (one stack a cycle), then moves the words in between, each by a read in MV_RD and a
// write in MV_WR, before EXEC runs again. in_ready is high only in IDLE, so a new word waits.
// Reset: stack marks are spread evenly at once; the data RAM is not cleared.
module shared_array_multi_stack
    import msstk_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [KIND_W-1:0]  kind,
    input  wire logic [INDEX_W-1:0] stack_index,
    input  wire logic [WORD_W-1:0]  push_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [WORD_W-1:0]  read_data,
    output logic                    was_empty,
    output logic                    was_full,
    output logic      [DEPTH_W-1:0] depth_after
);

    state_t                  state_reg, state_next;
    kind_t                   kind_reg;
    logic [SIDX_W-1:0]       s_reg;
    logic                    sok_reg;
    logic [DATA_WIDTH-1:0]   data_reg;
    logic [BIDX_W-1:0]       k_reg, k_next;
    logic                    up_reg, up_next;
    logic [PTR_W-1:0]        src_reg, src_next;
    logic [PTR_W-1:0]        cnt_reg, cnt_next;
    logic [BIDX_W-1:0]       lo_reg, lo_next;
    logic [BIDX_W-1:0]       hi_reg, hi_next;
    logic                    use_mem_reg, use_mem_next;
    logic                    res_empty_reg, res_empty_next;
    logic                    res_full_reg, res_full_next;
    logic [PTR_W-1:0]        res_depth_reg, res_depth_next;

    logic                    out_valid_reg;
    logic [WORD_W-1:0]       out_data_reg;
    logic                    out_empty_reg;
    logic                    out_full_reg;
    logic [DEPTH_W-1:0]      out_depth_reg;
    logic                    out_load;

    logic [DATA_WIDTH-1:0]   mem [CAPACITY];
    logic [DATA_WIDTH-1:0]   mem_rdata_reg;
    logic                    mem_we, mem_re;
    logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0]   mem_wdata;

    ptr_cmd_t                cmd;
    logic [SIDX_W-1:0]       top_idx;
    logic [BIDX_W-1:0]       base_idx;
    logic [PTR_W-1:0]        top_rd, base_rd;
    logic [STACKS-1:0]       free_vec, empty_vec;
    logic [PTR_W-1:0]        depth_now;
    logic [BIDX_W-1:0]       s_ext;

    msstk_ptrs u_ptrs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .top_idx   (top_idx),
        .base_idx  (base_idx),
        .top_rd    (top_rd),
        .base_rd   (base_rd),
        .free_vec  (free_vec),
        .empty_vec (empty_vec)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= mem[mem_raddr];
    end

    assign s_ext     = BIDX_W'(s_reg);
    assign depth_now = top_rd - base_rd;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        up_next        = up_reg;
        src_next       = src_reg;
        cnt_next       = cnt_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        use_mem_next   = use_mem_reg;
        res_empty_next = res_empty_reg;
        res_full_next  = res_full_reg;
        res_depth_next = res_depth_reg;
        cmd.op         = PTR_NONE;
        cmd.lo         = s_ext;
        cmd.hi         = s_ext;
        top_idx        = s_reg;
        base_idx       = s_ext;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = ADDR_W'(top_rd);
        mem_raddr      = ADDR_W'(top_rd - PTR_W'(1));
        mem_wdata      = data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end

            ST_EXEC:
            begin
                use_mem_next   = 1'b0;
                res_empty_next = 1'b0;
                res_full_next  = 1'b0;
                res_depth_next = depth_now;
                state_next     = ST_FINISH;
                if (!sok_reg)
                begin
                    res_depth_next = '0;
                end
                else
                begin
                    case (kind_reg)
                        KIND_PUSH:
                        begin
                            if (free_vec[s_reg])
                            begin
                                // The new word lands in slot top+1, which is RAM address top.
                                mem_we         = 1'b1;
                                cmd.op         = PTR_PUSH;
                                res_depth_next = depth_now + PTR_W'(1);
                            end
                            else
                            begin
                                k_next     = s_ext + BIDX_W'(1);
                                state_next = ST_UP_SCAN;
                            end
                        end
                        KIND_POP, KIND_PEEK:
                        begin
                            if (empty_vec[s_reg])
                            begin
                                res_empty_next = 1'b1;
                            end
                            else
                            begin
                                mem_re       = 1'b1;
                                use_mem_next = 1'b1;
                                if (kind_reg == KIND_POP)
                                begin
                                    cmd.op         = PTR_POP;
                                    res_depth_next = depth_now - PTR_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_UP_SCAN:
            begin
                if (k_reg == BIDX_W'(STACKS))
                begin
                    k_next     = s_ext;
                    state_next = ST_DN_SCAN;
                end
                else if (free_vec[SIDX_W'(k_reg)])
                begin
                    state_next = ST_UP_PREP;
                end
                else
                begin
                    k_next = k_reg + BIDX_W'(1);
                end
            end

            ST_UP_PREP:
            begin
                top_idx    = SIDX_W'(k_reg);
                base_idx   = s_ext + BIDX_W'(1);
                src_next   = top_rd;
                cnt_next   = top_rd - base_rd;
                lo_next    = s_ext + BIDX_W'(1);
                hi_next    = k_reg;
                up_next    = 1'b1;
                state_next = ST_MV_RD;
            end

            ST_DN_SCAN:
            begin
                if (k_reg == '0)
                begin
                    // No free slot anywhere: the push is dropped.
                    res_full_next = 1'b1;
                    state_next    = ST_FINISH;
                end
                else if (free_vec[SIDX_W'(k_reg - BIDX_W'(1))])
                begin
                    state_next = ST_DN_PREP;
                end
                else
                begin
                    k_next = k_reg - BIDX_W'(1);
                end
            end

            ST_DN_PREP:
            begin
                base_idx   = k_reg;
                src_next   = base_rd + PTR_W'(1);
                cnt_next   = top_rd - base_rd;
                lo_next    = k_reg;
                hi_next    = s_ext;
                up_next    = 1'b0;
                state_next = ST_MV_RD;
            end

            ST_MV_RD:
            begin
                if (cnt_reg == '0)
                begin
                    cmd.op     = up_reg ? PTR_SHIFT_UP : PTR_SHIFT_DOWN;
                    cmd.lo     = lo_reg;
                    cmd.hi     = hi_reg;
                    state_next = ST_EXEC;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ADDR_W'(src_reg - PTR_W'(1));
                    state_next = ST_MV_WR;
                end
            end

            ST_MV_WR:
            begin
                // Upward moves go from the top down, downward moves from the bottom up.
                mem_we    = 1'b1;
                mem_wdata = mem_rdata_reg;
                if (up_reg)
                begin
                    mem_waddr = ADDR_W'(src_reg);
                    src_next  = src_reg - PTR_W'(1);
                end
                else
                begin
                    mem_waddr = ADDR_W'(src_reg - PTR_W'(2));
                    src_next  = src_reg + PTR_W'(1);
                end
                cnt_next   = cnt_reg - PTR_W'(1);
                state_next = ST_MV_RD;
            end

            ST_FINISH:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            kind_reg <= kind_t'(kind);
            s_reg    <= SIDX_W'(stack_index);
            sok_reg  <= 32'(stack_index) < STACKS;
            data_reg <= DATA_WIDTH'(push_data);
        end
        k_reg         <= k_next;
        up_reg        <= up_next;
        src_reg       <= src_next;
        cnt_reg       <= cnt_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        use_mem_reg   <= use_mem_next;
        res_empty_reg <= res_empty_next;
        res_full_reg  <= res_full_next;
        res_depth_reg <= res_depth_next;
        if (out_load)
        begin
            out_data_reg  <= use_mem_reg ? WORD_W'(mem_rdata_reg) : '0;
            out_empty_reg <= res_empty_reg;
            out_full_reg  <= res_full_reg;
            out_depth_reg <= DEPTH_W'(res_depth_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = out_data_reg;
    assign was_empty   = out_empty_reg;
    assign was_full    = out_full_reg;
    assign depth_after = out_depth_reg;

endmodule
`default_nettype wire

// ----- dv/shared_array_multi_stack_tb.sv -----
`timescale 1ns / 1ps
module shared_array_multi_stack_tb;
    import msstk_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DIRECTED_ROWS  = 23;
    localparam int PHASE_WORDS    = 100;

    typedef struct packed {
        logic [WORD_W-1:0]  read_data;
        logic               was_empty;
        logic               was_full;
        logic [DEPTH_W-1:0] depth_after;
    } stack_reply_t;

    typedef struct packed {
        kind_t              op;
        logic [INDEX_W-1:0] stack_sel;
        logic [WORD_W-1:0]  word;
        logic               typed;
        stack_reply_t       reply;
    } stack_cmd_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [KIND_W-1:0]  kind = '0;
    logic [INDEX_W-1:0] stack_index = '0;
    logic [WORD_W-1:0]  push_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [WORD_W-1:0]  read_data;
    logic               was_empty;
    logic               was_full;
    logic [DEPTH_W-1:0] depth_after;

    // The typed expectation travels with the word and is used instead of the prediction.
    logic               typed_pending = 1'b0;
    stack_reply_t       typed_reply = '0;

    // Shadow of the shared memory and of the stack marks.
    logic [DATA_WIDTH-1:0] slots [1:CAPACITY];
    int                    mark_base [0:STACKS];
    int                    mark_top [0:STACKS-1];

    stack_reply_t pending_replies [$];
    int send_idle_pct = 10;
    int recv_idle_pct = 47;
    int idle_cycles = 0;
    int mismatches = 0;
    int replies_checked = 0;
    int pushes_taken = 0;
    int pushes_dropped = 0;
    int reads_taken = 0;
    int reads_empty = 0;
    int shifts_up = 0;
    int shifts_down = 0;

    stack_cmd_t directed_cmds [DIRECTED_ROWS] = '{
        '{KIND_POP,  4'd0,  16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0, 7'd0}},
        '{KIND_PEEK, 4'd15, 16'hFFFF, 1'b1, '{16'h0000, 1'b1, 1'b0, 7'd0}},
        '{KIND_NOP,  4'd7,  16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0, 7'd0}},
        '{KIND_PUSH, 4'd0,  16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0, 7'd1}},
        '{KIND_PUSH, 4'd0,  16'hFFFF, 1'b1, '{16'h0000, 1'b0, 1'b0, 7'd2}},
        '{KIND_PEEK, 4'd0,  16'h0000, 1'b1, '{16'hFFFF, 1'b0, 1'b0, 7'd2}},
        '{KIND_POP,  4'd0,  16'h0000, 1'b1, '{16'hFFFF, 1'b0, 1'b0, 7'd1}},
        '{KIND_PUSH, 4'd0,  16'hA5A5, 1'b1, '{16'h0000, 1'b0, 1'b0, 7'd2}},
        '{KIND_PUSH, 4'd0,  16'h5A5A, 1'b1, '{16'h0000, 1'b0, 1'b0, 7'd3}},
        '{KIND_PUSH, 4'd0,  16'h1234, 1'b1, '{16'h0000, 1'b0, 1'b0, 7'd4}},
        '{KIND_PUSH, 4'd0,  16'h8001, 1'b0, '0},
        '{KIND_PEEK, 4'd0,  16'h0000, 1'b0, '0},
        '{KIND_PUSH, 4'd15, 16'h0001, 1'b0, '0},
        '{KIND_PUSH, 4'd15, 16'h0002, 1'b0, '0},
        '{KIND_PUSH, 4'd15, 16'h0004, 1'b0, '0},
        '{KIND_PUSH, 4'd15, 16'h0008, 1'b0, '0},
        '{KIND_PUSH, 4'd15, 16'h8000, 1'b0, '0},
        '{KIND_POP,  4'd15, 16'h0000, 1'b0, '0},
        '{KIND_PEEK, 4'd15, 16'h0000, 1'b0, '0},
        '{KIND_NOP,  4'd0,  16'hFFFF, 1'b0, '0},
        '{KIND_POP,  4'd1,  16'h0000, 1'b0, '0},
        '{KIND_PUSH, 4'd1,  16'h7FFF, 1'b0, '0},
        '{KIND_POP,  4'd1,  16'h0000, 1'b0, '0}
    };

    shared_array_multi_stack i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .stack_index (stack_index),
        .push_data   (push_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_data   (read_data),
        .was_empty   (was_empty),
        .was_full    (was_full),
        .depth_after (depth_after)
    );

    always #5 clk = ~clk;

    function automatic stack_reply_t apply_stack_op(kind_t op, int s,
                                                    logic [WORD_W-1:0] data);
        stack_reply_t r;
        bit room;
        int k;
        int m;
        int j;
        r = '0;
        if (s >= STACKS)
            return r;
        room = 1'b1;
        if (op == KIND_PUSH && mark_top[s] == mark_base[s + 1])
        begin
            // Look upward for the nearest stack with room, then downward.
            room = 1'b0;
            for (k = s + 1; k < STACKS && !room; k++)
            begin
                if (mark_top[k] < mark_base[k + 1])
                begin
                    for (m = mark_top[k]; m > mark_base[s + 1]; m--)
                        slots[m + 1] = slots[m];
                    for (m = s + 1; m <= k; m++)
                    begin
                        mark_base[m]++;
                        mark_top[m]++;
                    end
                    room = 1'b1;
                    shifts_up++;
                end
            end
            for (k = s; k > 0 && !room; k--)
            begin
                j = k - 1;
                if (mark_top[j] < mark_base[j + 1])
                begin
                    for (m = mark_base[j + 1] + 1; m <= mark_top[s]; m++)
                        slots[m - 1] = slots[m];
                    for (m = j + 1; m <= s; m++)
                    begin
                        mark_base[m]--;
                        mark_top[m]--;
                    end
                    room = 1'b1;
                    shifts_down++;
                end
            end
        end
        case (op)
            KIND_PUSH:
            begin
                pushes_taken++;
                if (room)
                begin
                    mark_top[s]++;
                    slots[mark_top[s]] = data[DATA_WIDTH-1:0];
                end
                else
                begin
                    r.was_full = 1'b1;
                    pushes_dropped++;
                end
            end
            KIND_POP, KIND_PEEK:
            begin
                reads_taken++;
                if (mark_top[s] == mark_base[s])
                begin
                    r.was_empty = 1'b1;
                    reads_empty++;
                end
                else
                begin
                    r.read_data = WORD_W'(slots[mark_top[s]]);
                    if (op == KIND_POP)
                        mark_top[s]--;
                end
            end
            default:
            begin
            end
        endcase
        r.depth_after = DEPTH_W'(mark_top[s] - mark_base[s]);
        return r;
    endfunction

    // Holds the word until it is taken; idles first with the current sender rate.
    task automatic issue_word(input stack_cmd_t cmd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= cmd.op;
        stack_index   <= cmd.stack_sel;
        push_data     <= cmd.word;
        typed_pending <= cmd.typed;
        typed_reply   <= cmd.reply;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    always @(posedge clk)
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin : reply_check
        stack_reply_t want;
        stack_reply_t got;
        if (in_valid && in_ready)
        begin
            want = apply_stack_op(kind_t'(kind), int'(stack_index), push_data);
            pending_replies.push_back(typed_pending ? typed_reply : want);
        end
        if (out_valid && out_ready)
        begin
            got = '{read_data, was_empty, was_full, depth_after};
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected word rd=%h empty=%b full=%b depth=%0d",
                         $realtime, read_data, was_empty, was_full, depth_after);
                mismatches++;
            end
            else
            begin
                want = pending_replies.pop_front();
                replies_checked++;
                if (got.read_data !== want.read_data)
                begin
                    $display("%0t: read_data expected %h actual %h",
                             $realtime, want.read_data, got.read_data);
                    mismatches++;
                end
                if (got.was_empty !== want.was_empty)
                begin
                    $display("%0t: was_empty expected %b actual %b",
                             $realtime, want.was_empty, got.was_empty);
                    mismatches++;
                end
                if (got.was_full !== want.was_full)
                begin
                    $display("%0t: was_full expected %b actual %b",
                             $realtime, want.was_full, got.was_full);
                    mismatches++;
                end
                if (got.depth_after !== want.depth_after)
                begin
                    $display("%0t: depth_after expected %0d actual %0d",
                             $realtime, want.depth_after, got.depth_after);
                    mismatches++;
                end
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $realtime, idle_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        stack_cmd_t cmd;
        int regime;
        int phase;
        int pick;
        int row;
        bit hot;
        int hot_lo;
        for (int s = 0; s < STACKS; s++)
        begin
            mark_base[s] = (s * CAPACITY) / STACKS;
            mark_top[s]  = mark_base[s];
        end
        mark_base[STACKS] = CAPACITY;
        for (int n = 1; n <= CAPACITY; n++)
            slots[n] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DIRECTED_ROWS; row++)
            issue_word(directed_cmds[row]);

        // Each regime fills the memory past full, then drains most of it.
        for (regime = 0; regime < 3; regime++)
        begin
            send_idle_pct = (regime == 0) ? 10 : (regime == 1) ? 47 : 0;
            recv_idle_pct = (regime == 0) ? 47 : (regime == 1) ? 10 : 0;
            for (phase = 0; phase < 2; phase++)
            begin
                hot    = $urandom_range(1);
                hot_lo = $urandom_range(STACKS - 4);
                repeat (PHASE_WORDS)
                begin
                    pick = $urandom_range(99);
                    if (phase == 0)
                        cmd.op = (pick < 85) ? KIND_PUSH : (pick < 90) ? KIND_POP :
                                 (pick < 95) ? KIND_PEEK : KIND_NOP;
                    else
                        cmd.op = (pick < 75) ? KIND_POP : (pick < 85) ? KIND_PEEK :
                                 (pick < 95) ? KIND_PUSH : KIND_NOP;
                    if (hot && $urandom_range(1))
                        cmd.stack_sel = INDEX_W'(hot_lo + $urandom_range(3));
                    else
                        cmd.stack_sel = INDEX_W'($urandom_range(STACKS - 1));
                    if ($urandom_range(7) == 0)
                        cmd.word = $urandom_range(1) ? '1 : '0;
                    else
                        cmd.word = WORD_W'($urandom);
                    cmd.typed = 1'b0;
                    cmd.reply = '0;
                    issue_word(cmd);
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Checked %0d words: %0d pushes (%0d dropped on a full memory), %0d pops or peeks",
                 replies_checked, pushes_taken, pushes_dropped, reads_taken);
        $display("  (%0d on an empty stack), %0d upward and %0d downward neighbor shifts.",
                 reads_empty, shifts_up, shifts_down);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
